>>> hw/rtl/zvd_pkg.sv
// ----------------------------------------------------------------------------
// zvd_pkg
// Shared types and constants of the zero-velocity variance detector.
// ----------------------------------------------------------------------------
package zvd_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned SQ_W        = 2 * SAMPLE_BITS;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned THR_W       = 48;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [LEN_W-1:0] WINDOW_LENGTH_RST = 7'd32;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_CLEAR = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_ACC_THR       = 2'd1,
    REG_GYRO_THR      = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MUL,
    BK_CMP
  } back_state_e;

  typedef struct packed {
    op_e                    operation;
    logic [SAMPLE_BITS-1:0] acc_sample;
    logic [SAMPLE_BITS-1:0] gyro_sample;
  } in_item_t;

  typedef struct packed {
    logic stationary;
    logic window_full;
  } result_t;

  // One classified word from the front end to the back end
  typedef struct packed {
    op_e                    op;
    logic                   full;
    logic [SAMPLE_BITS-1:0] new_acc;
    logic [SAMPLE_BITS-1:0] old_acc;
    logic [SAMPLE_BITS-1:0] new_gyro;
    logic [SAMPLE_BITS-1:0] old_gyro;
    logic [SQ_W-1:0]        new_acc_sq;
    logic [SQ_W-1:0]        old_acc_sq;
    logic [SQ_W-1:0]        new_gyro_sq;
    logic [SQ_W-1:0]        old_gyro_sq;
  } work_t;

endpackage

>>> hw/rtl/zvd_front.sv
// ----------------------------------------------------------------------------
// zvd_front
// Accepts words, keeps the sample rings, fill count and write slot, and hands
// the new and evicted samples with their squares to the back end.
// ----------------------------------------------------------------------------
module zvd_front #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     push,
  output logic                                     full,
  input  zvd_pkg::in_item_t                        in_item_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]          n_i,
  input  logic                                     hist_clr_i,
  output logic                                     q_push_o,
  input  logic                                     q_full_i,
  output zvd_pkg::work_t                           q_data_o
);
  import zvd_pkg::*;

  localparam int unsigned NW     = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SLOT_W = $clog2(MAX_WINDOW);

  logic [SAMPLE_BITS-1:0] acc_mem  [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] gyro_mem [MAX_WINDOW];

  logic [NW-1:0]          fill_q, fill_d, fill_inc;
  logic [SLOT_W-1:0]      slot_q, slot_d, cur_slot, nxt_slot;
  logic [NW-1:0]          cur_ext;
  logic                   accept, is_push;

  logic                   st_valid_q, st_valid_d;
  op_e                    st_op_q;
  logic                   st_sub_q, st_full_q;
  logic [SAMPLE_BITS-1:0] st_acc_q, st_gyro_q;
  logic [SAMPLE_BITS-1:0] rd_acc_q, rd_gyro_q;
  logic [SAMPLE_BITS-1:0] old_acc, old_gyro;

  assign full     = st_valid_q && q_full_i;
  assign accept   = push && !full;
  assign is_push  = (in_item_i.operation == OP_PUSH);
  assign q_push_o = st_valid_q && !q_full_i;

  always_comb begin
    cur_slot = (NW'(slot_q) < n_i) ? slot_q : '0;
    cur_ext  = NW'(cur_slot);
    nxt_slot = (NW'(cur_ext + NW'(1)) >= n_i) ? '0 : SLOT_W'(cur_ext + NW'(1));
    fill_inc = (fill_q < n_i) ? NW'(fill_q + NW'(1)) : n_i;
  end

  always_comb begin
    fill_d = fill_q;
    slot_d = slot_q;
    if (hist_clr_i) begin
      fill_d = '0;
      slot_d = '0;
    end else if (accept) begin
      if (is_push) begin
        fill_d = fill_inc;
        slot_d = nxt_slot;
      end else begin
        fill_d = '0;
        slot_d = '0;
      end
    end
  end

  always_comb begin
    st_valid_d = st_valid_q;
    if (accept) begin
      st_valid_d = 1'b1;
    end else if (q_push_o) begin
      st_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      slot_q     <= '0;
      st_valid_q <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      slot_q     <= slot_d;
      st_valid_q <= st_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_op_q   <= in_item_i.operation;
      st_acc_q  <= in_item_i.acc_sample;
      st_gyro_q <= in_item_i.gyro_sample;
      // evict the oldest sample only once the window is full
      st_sub_q  <= is_push && (fill_q >= n_i);
      st_full_q <= is_push && (fill_inc == n_i);
    end
  end

  // Ring read returns the entry as it was before this write
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_acc_q  <= acc_mem[cur_slot];
      rd_gyro_q <= gyro_mem[cur_slot];
      if (is_push) begin
        acc_mem[cur_slot]  <= in_item_i.acc_sample;
        gyro_mem[cur_slot] <= in_item_i.gyro_sample;
      end
    end
  end

  assign old_acc  = st_sub_q ? rd_acc_q  : '0;
  assign old_gyro = st_sub_q ? rd_gyro_q : '0;

  always_comb begin
    q_data_o.op          = st_op_q;
    q_data_o.full        = st_full_q;
    q_data_o.new_acc     = st_acc_q;
    q_data_o.old_acc     = old_acc;
    q_data_o.new_gyro    = st_gyro_q;
    q_data_o.old_gyro    = old_gyro;
    q_data_o.new_acc_sq  = SQ_W'(st_acc_q) * SQ_W'(st_acc_q);
    q_data_o.old_acc_sq  = SQ_W'(old_acc) * SQ_W'(old_acc);
    q_data_o.new_gyro_sq = SQ_W'(st_gyro_q) * SQ_W'(st_gyro_q);
    q_data_o.old_gyro_sq = SQ_W'(old_gyro) * SQ_W'(old_gyro);
  end

endmodule

>>> hw/rtl/zvd_queue.sv
// ----------------------------------------------------------------------------
// zvd_queue
// Short first-in first-out buffer of work words between front and back end.
// ----------------------------------------------------------------------------
module zvd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  zvd_pkg::work_t data_i,
  input  logic           pop_i,
  output logic           empty_o,
  output zvd_pkg::work_t data_o
);
  import zvd_pkg::*;

  work_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entries[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = QCNT_W'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = QCNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/zvd_back.sv
// ----------------------------------------------------------------------------
// zvd_back
// Keeps running sums and sums of squares per channel and runs the exact
// variance test N*sumsq - sum^2 < thr*N^2 over an add, multiply, compare
// sequence. Holds one result for the consumer.
// ----------------------------------------------------------------------------
module zvd_back #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  q_empty_i,
  output logic                                  q_pop_o,
  input  zvd_pkg::work_t                        q_data_i,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]       n_i,
  input  logic [2*$clog2(MAX_WINDOW+1)-1:0]     nsq_i,
  input  logic [zvd_pkg::THR_W-1:0]             acc_thr_i,
  input  logic [zvd_pkg::THR_W-1:0]             gyro_thr_i,
  input  logic                                  hist_clr_i,
  output logic                                  empty,
  input  logic                                  pop,
  output zvd_pkg::result_t                      result_o
);
  import zvd_pkg::*;

  localparam int unsigned NW      = $clog2(MAX_WINDOW + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_WINDOW);
  localparam int unsigned SUM_W   = SAMPLE_BITS + IDX_W;
  localparam int unsigned SUMSQ_W = SQ_W + IDX_W;
  localparam int unsigned LHS_W   = SUMSQ_W + NW;
  localparam int unsigned S2_W    = 2 * SUM_W;
  localparam int unsigned T_W     = THR_W + 2 * NW;
  localparam int unsigned CMP_W0  = (LHS_W > S2_W) ? LHS_W : S2_W;
  localparam int unsigned CMP_W   = ((CMP_W0 > T_W) ? CMP_W0 : T_W) + 1;

  back_state_e          state_q, state_d;
  logic [SUM_W-1:0]     acc_sum_q, acc_sum_d, gyro_sum_q, gyro_sum_d;
  logic [SUMSQ_W-1:0]   acc_sumsq_q, acc_sumsq_d, gyro_sumsq_q, gyro_sumsq_d;
  logic [LHS_W-1:0]     acc_lhs_q, gyro_lhs_q;
  logic [S2_W-1:0]      acc_s2_q, gyro_s2_q;
  logic [T_W-1:0]       acc_t_q, gyro_t_q;
  logic                 out_valid_q, out_valid_d;
  result_t              res_q, res_d;
  logic                 mul_en, take, acc_lt, gyro_lt;

  assign take     = !q_empty_i && !out_valid_q;
  assign empty    = !out_valid_q;
  assign result_o = res_q;

  assign acc_lt  = CMP_W'(acc_lhs_q)  < CMP_W'(CMP_W'(acc_s2_q)  + CMP_W'(acc_t_q));
  assign gyro_lt = CMP_W'(gyro_lhs_q) < CMP_W'(CMP_W'(gyro_s2_q) + CMP_W'(gyro_t_q));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (take && (q_data_i.op == OP_PUSH) && q_data_i.full) begin
          state_d = BK_MUL;
        end
      end
      BK_MUL:  state_d = BK_CMP;
      BK_CMP:  state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o      = 1'b0;
    mul_en       = 1'b0;
    acc_sum_d    = acc_sum_q;
    gyro_sum_d   = gyro_sum_q;
    acc_sumsq_d  = acc_sumsq_q;
    gyro_sumsq_d = gyro_sumsq_q;
    out_valid_d  = out_valid_q && !pop;
    res_d        = res_q;
    if (hist_clr_i) begin
      acc_sum_d    = '0;
      gyro_sum_d   = '0;
      acc_sumsq_d  = '0;
      gyro_sumsq_d = '0;
    end
    unique case (state_q)
      BK_IDLE: begin
        if (take) begin
          q_pop_o = 1'b1;
          if (q_data_i.op == OP_CLEAR) begin
            acc_sum_d    = '0;
            gyro_sum_d   = '0;
            acc_sumsq_d  = '0;
            gyro_sumsq_d = '0;
            out_valid_d  = 1'b1;
            res_d        = '{stationary: 1'b0, window_full: 1'b0};
          end else begin
            // add the new sample, drop the evicted one
            acc_sum_d    = SUM_W'(acc_sum_q + SUM_W'(q_data_i.new_acc)
                                 - SUM_W'(q_data_i.old_acc));
            gyro_sum_d   = SUM_W'(gyro_sum_q + SUM_W'(q_data_i.new_gyro)
                                 - SUM_W'(q_data_i.old_gyro));
            acc_sumsq_d  = SUMSQ_W'(acc_sumsq_q + SUMSQ_W'(q_data_i.new_acc_sq)
                                   - SUMSQ_W'(q_data_i.old_acc_sq));
            gyro_sumsq_d = SUMSQ_W'(gyro_sumsq_q + SUMSQ_W'(q_data_i.new_gyro_sq)
                                   - SUMSQ_W'(q_data_i.old_gyro_sq));
            if (!q_data_i.full) begin
              out_valid_d = 1'b1;
              res_d       = '{stationary: 1'b0, window_full: 1'b0};
            end
          end
        end
      end
      BK_MUL: begin
        mul_en = 1'b1;
      end
      BK_CMP: begin
        out_valid_d = 1'b1;
        res_d       = '{stationary: acc_lt && gyro_lt, window_full: 1'b1};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= BK_IDLE;
      acc_sum_q    <= '0;
      gyro_sum_q   <= '0;
      acc_sumsq_q  <= '0;
      gyro_sumsq_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      acc_sum_q    <= acc_sum_d;
      gyro_sum_q   <= gyro_sum_d;
      acc_sumsq_q  <= acc_sumsq_d;
      gyro_sumsq_q <= gyro_sumsq_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (mul_en) begin
      acc_lhs_q  <= LHS_W'(acc_sumsq_q) * LHS_W'(n_i);
      gyro_lhs_q <= LHS_W'(gyro_sumsq_q) * LHS_W'(n_i);
      acc_s2_q   <= S2_W'(acc_sum_q) * S2_W'(acc_sum_q);
      gyro_s2_q  <= S2_W'(gyro_sum_q) * S2_W'(gyro_sum_q);
      acc_t_q    <= T_W'(acc_thr_i) * T_W'(nsq_i);
      gyro_t_q   <= T_W'(gyro_thr_i) * T_W'(nsq_i);
    end
  end

endmodule

>>> hw/rtl/zero_velocity_variance_detector_unit.sv
// ----------------------------------------------------------------------------
// zero_velocity_variance_detector_unit
// Sliding-window stationary detector on acceleration and gyro norm samples.
//
//   Channel   Handshake                     Payload
//   input     push / full                   in_item_i  (operation, samples)
//   result    empty / pop                   result_o   (stationary, window_full)
//   config    cfg_valid_i / cfg_ready_o     cfg_index_i, cfg_data_i
//
// A word is held in the front-end stage register (ring read, squares), then
// enters a two-deep queue. The back end takes a new word only when it is idle
// and no result waits for pop, so it takes the next word only after the last one
// has gone through its sequence (sum update, multiply, compare, pop; multiply and
// compare only with a full window) and its result register. Reset clears fill
// count, write slot and running sums; the rings are not cleared, so no sweep
// follows reset. The queue takes input while a result waits for pop.
// ----------------------------------------------------------------------------
module zero_velocity_variance_detector_unit #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  zvd_pkg::in_item_t                 in_item_i,
  output logic                              empty,
  input  logic                              pop,
  output zvd_pkg::result_t                  result_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [zvd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [zvd_pkg::THR_W-1:0]         cfg_data_i
);
  import zvd_pkg::*;

  localparam int unsigned NW    = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CL_W  = (NW > LEN_W) ? NW : LEN_W;
  localparam int unsigned N_RST = (int'(WINDOW_LENGTH_RST) > MAX_WINDOW) ?
                                  MAX_WINDOW : int'(WINDOW_LENGTH_RST);

  logic [NW-1:0]     n_q, n_new;
  logic [2*NW-1:0]   nsq_q, nsq_new;
  logic [THR_W-1:0]  acc_thr_q, gyro_thr_q;
  logic [CL_W-1:0]   len_ext;
  logic              cfg_we, hist_clr;

  logic              q_push, q_full, q_pop, q_empty;
  work_t             q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign hist_clr    = cfg_we && (cfg_index_i == REG_WINDOW_LENGTH);

  // zero acts as one, anything past the ring depth acts as the depth
  always_comb begin
    len_ext = CL_W'(cfg_data_i[LEN_W-1:0]);
    if (len_ext == '0) begin
      n_new = NW'(1);
    end else if (len_ext > CL_W'(MAX_WINDOW)) begin
      n_new = NW'(MAX_WINDOW);
    end else begin
      n_new = NW'(len_ext);
    end
    nsq_new = (2*NW)'(n_new) * (2*NW)'(n_new);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q        <= NW'(N_RST);
      nsq_q      <= (2*NW)'(N_RST * N_RST);
      acc_thr_q  <= '0;
      gyro_thr_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_WINDOW_LENGTH: begin
          n_q   <= n_new;
          nsq_q <= nsq_new;
        end
        REG_ACC_THR:  acc_thr_q  <= cfg_data_i;
        REG_GYRO_THR: gyro_thr_q <= cfg_data_i;
        default: begin
          acc_thr_q <= acc_thr_q;
        end
      endcase
    end
  end

  zvd_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .n_i        (n_q),
    .hist_clr_i (hist_clr),
    .q_push_o   (q_push),
    .q_full_i   (q_full),
    .q_data_o   (q_wdata)
  );

  zvd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  zvd_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .q_data_i   (q_rdata),
    .n_i        (n_q),
    .nsq_i      (nsq_q),
    .acc_thr_i  (acc_thr_q),
    .gyro_thr_i (gyro_thr_q),
    .hist_clr_i (hist_clr),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

endmodule

>>> hw/rtl/zvd_checker.sv
// ----------------------------------------------------------------------------
// zvd_checker
// Port-level checks of the detector, attached to the top level by bind.
// ----------------------------------------------------------------------------
module zvd_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             full,
  input  logic             empty,
  input  logic             pop,
  input  zvd_pkg::result_t result_o
);
  import zvd_pkg::*;

  // stationary only ever comes with a full window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (!result_o.stationary || result_o.window_full))
  else $error("stationary reported without a full window");

  // nothing waits on the result side right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> empty)
  else $error("result present right after reset");

  // the input side is open right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !full)
  else $error("input full right after reset");

  // hold a result that was not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
  else $error("waiting result changed or vanished");

endmodule

bind zero_velocity_variance_detector_unit zvd_checker u_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);
